// File: design/frma_pkg.sv
// Package of shared constants and types for the frame rate moving average.
`timescale 1ns / 1ps

package frma_pkg;

    // Number of entries in the rate ring.
    localparam int RING_DEPTH = 32;

    localparam int PTR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RATE_W    = 10;
    localparam int FT_W      = 16;
    localparam int THR_W     = 16;
    localparam int CATCH_W   = 6;
    localparam int RATE_MAX  = 1000;
    localparam int RATE_FAST = 500;
    localparam int SUM_MAX   = RATE_MAX * RING_DEPTH;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int DIV_W     = (SUM_W > FT_W) ? SUM_W : FT_W;
    localparam int CNT_W     = (CATCH_W > PTR_W + 1) ? CATCH_W : PTR_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CATCHUP_COUNT  = 1'b1;

    localparam logic [THR_W-1:0]   THR_RESET   = 16'd10;
    localparam logic [CATCH_W-1:0] CATCH_RESET = 6'd4;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: design/frma_if.sv
// Handshake interfaces for the frame, result and configuration channels.
`timescale 1ns / 1ps

interface frma_in_if import frma_pkg::*;;
    logic            valid;
    logic            ready;
    logic [FT_W-1:0] frame_time_ms;

    modport source (output valid, output frame_time_ms, input ready);
    modport sink   (input valid, input frame_time_ms, output ready);
endinterface

interface frma_out_if import frma_pkg::*;;
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] avg_rate;

    modport source (output valid, output avg_rate, input ready);
    modport sink   (input valid, input avg_rate, output ready);
endinterface

interface frma_cfg_if import frma_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/frma_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module frma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/frma_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module frma_div import frma_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (trial[DIV_W])
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            step_next = STEP_W'(DIV_W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: design/frame_rate_moving_average.sv
// Frame rate moving average: sequencer, rate ring and result register.
// Usage:
// The frame channel takes one frame time in milliseconds per request; the
// result channel returns one averaged frame rate per frame request. The
// configuration channel writes the difference threshold (index 0) and the
// catch-up count (index 1); it is always ready and should be written only
// while no frame is in progress.
// Each frame runs through one shared divider (one quotient bit per cycle)
// and a ring RAM with a registered read port. A frame takes the rate
// division unless its time is zero, the averaged time division when the
// rate is below 500 and the sum is not zero, and a read state and a write
// state per ring insertion; the first frame after reset instead writes the
// whole ring, one entry per cycle. Frame ready is high only when idle and
// rises together with the result.
// A finished result sits in an output register; the next frame is accepted
// while it waits, but that frame's result is held back until the receiver
// takes the previous one.
// Reset clears the sum, the ring pointer and the primed flag, and loads the
// threshold with 10 and the catch-up count with 4. The ring needs no clear:
// the first frame overwrites every entry.
`timescale 1ns / 1ps

module frame_rate_moving_average import frma_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    frma_cfg_if.sink   cfg,
    frma_in_if.sink    frame,
    frma_out_if.source result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_RATE,
        S_DECIDE,
        S_DIV_AVG,
        S_FILL,
        S_RD,
        S_WR,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [FT_W-1:0]     ft_reg, ft_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                primed_reg, primed_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [CATCH_W-1:0]  catch_reg, catch_next;
    logic [RATE_W-1:0]   avg_reg, avg_next;
    logic                out_valid_reg, out_valid_next;

    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic                ram_we;
    logic [RATE_W-1:0]   ram_rdata;
    logic [DIV_W-1:0]    avg_time;
    logic [DIV_W-1:0]    ft_wide;
    logic [DIV_W-1:0]    diff;
    logic                frame_acc;

    frma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    frma_ram #(
        .WIDTH (RATE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ptr_reg),
        .wdata (rate_reg),
        .rdata (ram_rdata)
    );

    assign frame.ready   = (state_reg == S_IDLE);
    assign frame_acc     = frame.valid && frame.ready;
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.avg_rate = avg_reg;

    assign ram_we   = (state_reg == S_FILL) || (state_reg == S_WR);
    assign avg_time = div_rsp.quotient;
    assign ft_wide  = DIV_W'(ft_reg);
    assign diff     = (avg_time >= ft_wide) ? (avg_time - ft_wide) : (ft_wide - avg_time);

    always_comb
    begin
        state_next     = state_reg;
        ft_next        = ft_reg;
        rate_next      = rate_reg;
        sum_next       = sum_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        primed_next    = primed_reg;
        thr_next       = thr_reg;
        catch_next     = catch_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg;
        div_req        = '0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DIFF_THRESHOLD: thr_next   = cfg.data[THR_W-1:0];
                CFG_CATCHUP_COUNT:  catch_next = cfg.data[CATCH_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame_acc)
                begin
                    ft_next = frame.frame_time_ms;
                    if (frame.frame_time_ms == '0)
                    begin
                        rate_next  = RATE_W'(RATE_MAX);
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(RATE_MAX);
                        div_req.divisor  = DIV_W'(frame.frame_time_ms);
                        state_next       = S_DIV_RATE;
                    end
                end
            end
            S_DIV_RATE:
            begin
                if (div_rsp.done)
                begin
                    rate_next  = div_rsp.quotient[RATE_W-1:0];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!primed_reg)
                begin
                    // The first frame writes every entry; the ring pointer is zero here.
                    primed_next = 1'b1;
                    cnt_next    = CNT_W'(RING_DEPTH);
                    state_next  = S_FILL;
                end
                else if (rate_reg >= RATE_W'(RATE_FAST))
                begin
                    cnt_next   = CNT_W'(1);
                    state_next = S_RD;
                end
                else if (sum_reg == '0)
                begin
                    cnt_next   = CNT_W'(catch_reg);
                    state_next = (catch_reg == '0) ? S_DONE : S_RD;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(SUM_MAX);
                    div_req.divisor  = DIV_W'(sum_reg);
                    state_next       = S_DIV_AVG;
                end
            end
            S_DIV_AVG:
            begin
                if (div_rsp.done)
                begin
                    if (diff <= DIV_W'(thr_reg))
                    begin
                        cnt_next   = CNT_W'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        cnt_next   = CNT_W'(catch_reg);
                        state_next = (catch_reg == '0) ? S_DONE : S_RD;
                    end
                end
            end
            S_FILL:
            begin
                sum_next = sum_reg + SUM_W'(rate_reg);
                ptr_next = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                sum_next = sum_reg - SUM_W'(ram_rdata) + SUM_W'(rate_reg);
                ptr_next = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
                cnt_next = cnt_reg - CNT_W'(1);
                state_next = (cnt_reg == CNT_W'(1)) ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                // Hold the new result until the previous one has been taken.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = RATE_W'(sum_reg / SUM_W'(RING_DEPTH));
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ft_reg        <= '0;
            rate_reg      <= '0;
            sum_reg       <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            primed_reg    <= 1'b0;
            thr_reg       <= THR_RESET;
            catch_reg     <= CATCH_RESET;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ft_reg        <= ft_next;
            rate_reg      <= rate_next;
            sum_reg       <= sum_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            primed_reg    <= primed_next;
            thr_reg       <= thr_next;
            catch_reg     <= catch_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The running sum can never exceed a ring full of the largest rate.
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(SUM_MAX))
        else $error("ring sum out of range");

    // Divider results arrive only while the sequencer waits for one.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_RATE || state_reg == S_DIV_AVG))
        else $error("unexpected divider result");

    // A result appears only as the sequencer leaves its completion state.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside completion");

    // Once the ring has been filled it stays filled.
    a_primed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");

    // A waiting result must not be overwritten by the next frame.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(avg_reg))
        else $error("pending result lost");

endmodule
